>>> hw/rtl/stq_pkg.sv
// ============================================================================
// stq_pkg
// Shared types and constants of the sorted timer queue.
// ============================================================================
`timescale 1ns / 1ps

package stq_pkg;

    // Number of timer slots and derived widths.
    localparam int TIMERS = 16;
    localparam int SLOT_W = $clog2(TIMERS);
    localparam int CNT_W  = $clog2(TIMERS + 1);

    // Fixed field widths.
    localparam int OP_W    = 2;
    localparam int ID_W    = 4;
    localparam int DELAY_W = 31;
    localparam int TIME_W  = 32;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 40;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_UNL_WALK,
        ST_INS_START,
        ST_INS_WALK,
        ST_HEAD,
        ST_STATUS,
        ST_TCHK,
        ST_FIRE,
        ST_FHEAD,
        ST_FEMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic walk_start;
        logic walk_step;
        logic unlink;
        logic insert;
        logic fire;
        logic emit;
        logic emit_fire;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_ok;
        logic            id_armed;
        logic            cur_is_id;
        logic            ins_more;
        logic            head_due;
        logic            out_free;
    } sts_t;

endpackage

>>> hw/rtl/stq_ctrl.sv
// ============================================================================
// stq_ctrl
// Sequencer for list walks, insertion, removal and result emission.
// ============================================================================
`timescale 1ns / 1ps

module stq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  stq_pkg::sts_t  sts,
    output stq_pkg::cmd_t  cmd
);

    stq_pkg::state_t state_reg;
    stq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stq_pkg::ST_DISPATCH;
                end
            end
            stq_pkg::ST_DISPATCH:
            begin
                cmd.walk_start = 1'b1;
                if (sts.op == stq_pkg::OP_TICK)
                begin
                    state_next = stq_pkg::ST_TCHK;
                end
                else if ((sts.op == stq_pkg::OP_SET || sts.op == stq_pkg::OP_CLEAR)
                         && sts.id_ok)
                begin
                    if (sts.id_armed)
                    begin
                        state_next = stq_pkg::ST_UNL_WALK;
                    end
                    else if (sts.op == stq_pkg::OP_SET)
                    begin
                        state_next = stq_pkg::ST_INS_WALK;
                    end
                    else
                    begin
                        state_next = stq_pkg::ST_STATUS;
                    end
                end
                else
                begin
                    state_next = stq_pkg::ST_STATUS;
                end
            end
            stq_pkg::ST_UNL_WALK:
            begin
                if (sts.cur_is_id)
                begin
                    cmd.unlink = 1'b1;
                    state_next = (sts.op == stq_pkg::OP_SET) ? stq_pkg::ST_INS_START
                                                             : stq_pkg::ST_HEAD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            stq_pkg::ST_INS_START:
            begin
                cmd.walk_start = 1'b1;
                state_next     = stq_pkg::ST_INS_WALK;
            end
            stq_pkg::ST_INS_WALK:
            begin
                if (sts.ins_more)
                begin
                    cmd.walk_step = 1'b1;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = stq_pkg::ST_HEAD;
                end
            end
            stq_pkg::ST_HEAD:
            begin
                cmd.walk_start = 1'b1;
                state_next     = stq_pkg::ST_STATUS;
            end
            stq_pkg::ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_TCHK:
            begin
                state_next = sts.head_due ? stq_pkg::ST_FIRE : stq_pkg::ST_STATUS;
            end
            stq_pkg::ST_FIRE:
            begin
                cmd.fire   = 1'b1;
                state_next = stq_pkg::ST_FHEAD;
            end
            stq_pkg::ST_FHEAD:
            begin
                cmd.walk_start = 1'b1;
                state_next     = stq_pkg::ST_FEMIT;
            end
            stq_pkg::ST_FEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_fire = 1'b1;
                    state_next    = sts.head_due ? stq_pkg::ST_FIRE : stq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/stq_dp.sv
// ============================================================================
// stq_dp
// Timer list storage, walk pointers and the result register.
// ============================================================================
`timescale 1ns / 1ps

module stq_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  stq_pkg::cmd_t                 cmd,
    output stq_pkg::sts_t                 sts,
    input  logic [stq_pkg::S_DATA_W-1:0]  s_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [stq_pkg::M_DATA_W-1:0]  out_data,
    output logic                          out_last,
    output logic                          out_fired
);

    // List storage.
    logic [stq_pkg::TIME_W-1:0] expiry_mem [stq_pkg::TIMERS];
    logic [stq_pkg::SLOT_W-1:0] link_reg   [stq_pkg::TIMERS];
    logic [stq_pkg::TIMERS-1:0] armed_reg;
    logic [stq_pkg::SLOT_W-1:0] head_reg;
    logic [stq_pkg::CNT_W-1:0]  count_reg;

    // Walk and item registers.
    logic [stq_pkg::SLOT_W-1:0] cur_reg;
    logic [stq_pkg::SLOT_W-1:0] prev_reg;
    logic                       have_prev_reg;
    logic [stq_pkg::CNT_W-1:0]  step_reg;
    logic [stq_pkg::OP_W-1:0]   op_reg;
    logic [stq_pkg::ID_W-1:0]   id_reg;
    logic [stq_pkg::TIME_W-1:0] now_reg;
    logic [stq_pkg::TIME_W-1:0] when_reg;
    logic [stq_pkg::SLOT_W-1:0] fired_reg;

    // Result register.
    logic                       out_valid_reg;
    logic                       out_fired_reg;
    logic                       out_last_reg;
    logic [stq_pkg::ID_W-1:0]   out_id_reg;
    logic                       out_pend_reg;
    logic [stq_pkg::TIME_W-1:0] out_exp_reg;

    logic [stq_pkg::SLOT_W-1:0] slot;
    logic [stq_pkg::TIME_W-1:0] cur_exp;
    logic [stq_pkg::SLOT_W-1:0] cur_link;
    logic [stq_pkg::TIME_W-1:0] due_diff;
    logic [stq_pkg::TIME_W-1:0] ins_diff;
    logic                       head_due;
    logic                       out_free;

    assign slot     = id_reg[stq_pkg::SLOT_W-1:0];
    assign cur_exp  = expiry_mem[cur_reg];
    assign cur_link = link_reg[cur_reg];
    assign due_diff = cur_exp - now_reg;
    assign ins_diff = cur_exp - when_reg;
    assign head_due = (count_reg != '0)
                      && ((due_diff == '0) || due_diff[stq_pkg::TIME_W-1]);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts           = '0;
        sts.op        = op_reg;
        sts.id_ok     = (32'(id_reg) < stq_pkg::TIMERS);
        sts.id_armed  = armed_reg[slot];
        sts.cur_is_id = (cur_reg == slot);
        sts.ins_more  = (step_reg < count_reg) && ins_diff[stq_pkg::TIME_W-1];
        sts.head_due  = head_due;
        sts.out_free  = out_free;
    end

    // Expiration memory: one write port, read at the walk pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            expiry_mem[slot] <= when_reg;
        end
    end

    // Link storage and item registers (payload, no reset).
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= s_data[1:0];
            id_reg   <= s_data[5:2];
            now_reg  <= s_data[68:37];
            when_reg <= s_data[68:37] + {1'b0, s_data[36:6]};
        end
        if (cmd.walk_start)
        begin
            cur_reg <= head_reg;
        end
        else if (cmd.walk_step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= cur_link;
        end
        if (cmd.fire)
        begin
            fired_reg <= cur_reg;
        end
        if (cmd.unlink && have_prev_reg)
        begin
            link_reg[prev_reg] <= cur_link;
        end
        if (cmd.insert)
        begin
            link_reg[slot] <= (step_reg < count_reg) ? cur_reg : slot;
            if (have_prev_reg)
            begin
                link_reg[prev_reg] <= slot;
            end
        end
        if (cmd.emit)
        begin
            out_fired_reg <= cmd.emit_fire;
            out_last_reg  <= cmd.emit_fire ? !head_due : 1'b1;
            out_id_reg    <= cmd.emit_fire ? stq_pkg::ID_W'(fired_reg) : '0;
            out_pend_reg  <= (count_reg != '0);
            out_exp_reg   <= (count_reg != '0) ? cur_exp : '0;
        end
    end

    // List control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            have_prev_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.walk_start)
            begin
                have_prev_reg <= 1'b0;
                step_reg      <= '0;
            end
            else if (cmd.walk_step)
            begin
                have_prev_reg <= 1'b1;
                step_reg      <= step_reg + 1'b1;
            end
            if (cmd.unlink || cmd.fire)
            begin
                armed_reg[cur_reg] <= 1'b0;
                count_reg          <= count_reg - 1'b1;
                if (count_reg == stq_pkg::CNT_W'(1))
                begin
                    head_reg <= '0;
                end
                else if (cmd.fire || !have_prev_reg)
                begin
                    head_reg <= cur_link;
                end
            end
            if (cmd.insert)
            begin
                armed_reg[slot] <= 1'b1;
                count_reg       <= count_reg + 1'b1;
                if (!have_prev_reg)
                begin
                    head_reg <= slot;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_fired = out_fired_reg;
    assign out_data  = {3'b000, out_exp_reg, out_pend_reg, out_id_reg};

endmodule

>>> hw/rtl/sorted_timer_queue.sv
// ============================================================================
// sorted_timer_queue
// Software timer list kept in order of expiration, with set, clear and tick.
// ============================================================================
// Usage: the slave stream carries commands (tick, set, clear). A set arms a
// slot at now plus delay, replacing any earlier arming; a clear disarms it.
// A tick fires every timer whose expiration is not after now, in list
// order. The master stream carries results: a set, a clear or a tick with
// nothing due gives one status item; a tick that fires timers gives one
// item per fired timer, tuser high, with tlast on the final one. Every item
// reports whether timers remain armed and the earliest pending expiration.
// Commands are handled one at a time: the next command is accepted only
// once the result of the last one is loaded into the output register.
// A tick fires due timers one by one from the list head. A set or clear of
// an armed timer walks the list to unlink it, and a set then walks it again
// to find its place in expiration order. The list walk, which follows one
// link per cycle, sets the cost.
// Reset clears all armed flags and empties the list; no clearing pass.
// When the receiver stalls, a finished item waits in the output register
// and the sequencer holds before producing the next one.
`timescale 1ns / 1ps

module sorted_timer_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], timer_id[5:2], delay_ms[36:6], now_ms[68:37], zeros above.
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // fired_id[3:0], any_pending[4], next_expiration[36:5], zeros above.
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // fired_valid[0].
    output logic        m_tuser
);

    // Command and status between the sequencer and the datapath.
    stq_pkg::cmd_t cmd;
    stq_pkg::sts_t sts;

    stq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stq_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_fired (m_tuser)
    );

endmodule

>>> hw/rtl/stq_checker.sv
// ============================================================================
// stq_checker
// Port-level checks of the sorted timer queue.
// ============================================================================
`timescale 1ns / 1ps

module stq_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser
);

    // A held result must stay offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A status result is always the final one of its command.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("status result without tlast");

    // Nothing pending means a zero expiration.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> (m_tdata[36:5] == 32'd0))
        else $error("expiration reported with empty list");

    // Status results carry slot zero.
    a_status_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[3:0] == 4'd0))
        else $error("status result with nonzero slot");

endmodule

bind sorted_timer_queue stq_checker u_stq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
